[hdl/tscd_pkg.sv]
// Shared types, constants and the month length table for the timestamp to date converter.
`default_nettype none

package tscd_pkg;

   localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
   localparam logic [11:0] LAST_YEAR   = 12'd2106;
   // 1970 mod 4, mod 100 and mod 400
   localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
   localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
   localparam logic [6:0]  MOD100_LAST  = 7'd99;
   localparam logic [8:0]  MOD400_LAST  = 9'd399;

   localparam logic [8:0]  DAYS_COMMON = 9'd365;
   localparam logic [8:0]  DAYS_LEAP   = 9'd366;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   // exact reciprocals: (secs >> 7) / 675, (tod >> 4) / 225, (rest >> 2) / 15
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;   // 2^35 / 675, rounded up
   localparam logic [13:0] HOUR_RECIP = 14'd9321;       // 2^21 / 225, rounded up
   localparam logic [10:0] MIN_RECIP  = 11'd1093;       // 2^14 / 15, rounded up

   localparam logic [3:0]  MONTH_JAN = 4'd0;
   localparam logic [3:0]  MONTH_FEB = 4'd1;
   localparam logic [3:0]  MONTH_DEC = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DAYS,
      ST_TOD,
      ST_HOURS,
      ST_HOUR_REM,
      ST_MINUTES,
      ST_SECONDS,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } tscd_state_type;

   typedef struct packed {
      logic load;
      logic days_calc;
      logic tod_calc;
      logic hour_calc;
      logic hrem_calc;
      logic min_calc;
      logic sec_calc;
      logic year_step;
      logic month_step;
      logic out_load;
   } tscd_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } tscd_status_type;

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      begin
         case (mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd31;
         endcase
         month_days = len;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/timestamp_to_civil_date_unit.sv]
// Sequence: an accepted item runs 6 divide stages, then one year step per year walked (up
//   to 136) and one month step per month (up to 11), then the result is loaded and rsp_tvalid rises.
// Items: one at a time; the next item is taken once the result sits in the output register,
//   and it waits to finish until that result is taken.
// Reset: synchronous, active high; clears the controller and the result valid flag.
// Top level: seconds since 1970 to Gregorian date and time of day.
`default_nettype none

module timestamp_to_civil_date_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata    // [11:0] year, [15:12] month, [20:16] day,
                                    // [25:21] hour, [31:26] minute, [37:32] second
);

   tscd_pkg::tscd_cmd_type    cmd;
   tscd_pkg::tscd_status_type status;

   tscd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tscd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .epoch_seconds (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_data      (rsp_tdata)
   );

endmodule

`default_nettype wire

[hdl/tscd_dp.sv]
// Datapath: reciprocal divide stages, year and month walk, result register.
`default_nettype none

module tscd_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [31:0]            epoch_seconds,
   input  tscd_pkg::tscd_cmd_type cmd,
   output tscd_pkg::tscd_status_type status,
   output logic [39:0]            rsp_data
);

   logic [31:0] secs_ff, secs_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;
   logic [4:0]  hour_ff, hour_in;
   logic [11:0] hrem_ff, hrem_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [11:0] year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  mon_ff, mon_in;
   logic [39:0] out_ff, out_in;

   logic [50:0] day_prod;
   logic [16:0] day_secs;
   logic [26:0] hour_prod;
   logic [11:0] hour_secs;
   logic [20:0] min_prod;
   logic [5:0]  min_secs;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [3:0]  month_out;
   logic [4:0]  day_out;

   assign day_prod  = {26'd0, secs_ff[31:7]} * {25'd0, tscd_pkg::DAY_RECIP};
   // only the low bits are needed, the true difference is below the modulus
   assign day_secs  = {1'b0, days_ff} * tscd_pkg::SECS_PER_DAY;
   assign hour_prod = {14'd0, tod_ff[16:4]} * {13'd0, tscd_pkg::HOUR_RECIP};
   assign hour_secs = {7'd0, hour_ff} * tscd_pkg::SECS_PER_HOUR;
   assign min_prod  = {11'd0, hrem_ff[11:2]} * {10'd0, tscd_pkg::MIN_RECIP};
   assign min_secs  = min_ff * tscd_pkg::SECS_PER_MIN;

   assign leap = (mod4_ff == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));
   assign ylen = leap ? tscd_pkg::DAYS_LEAP : tscd_pkg::DAYS_COMMON;
   assign mlen = tscd_pkg::month_days(mon_ff, leap);

   assign status.year_done  = (days_ff < {7'd0, ylen});
   assign status.month_done = (mon_ff == tscd_pkg::MONTH_DEC) || (days_ff < {11'd0, mlen});

   assign month_out = mon_ff + 4'd1;
   assign day_out   = days_ff[4:0] + 5'd1;

   always_comb begin
      secs_in   = secs_ff;
      days_in   = days_ff;
      tod_in    = tod_ff;
      hour_in   = hour_ff;
      hrem_in   = hrem_ff;
      min_in    = min_ff;
      sec_in    = sec_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      mon_in    = mon_ff;
      out_in    = out_ff;
      if (cmd.load) begin
         secs_in   = epoch_seconds;
         year_in   = tscd_pkg::EPOCH_YEAR;
         mod4_in   = tscd_pkg::EPOCH_MOD4;
         mod100_in = tscd_pkg::EPOCH_MOD100;
         mod400_in = tscd_pkg::EPOCH_MOD400;
         mon_in    = tscd_pkg::MONTH_JAN;
      end
      if (cmd.days_calc) begin
         days_in = day_prod[50:35];
      end
      if (cmd.tod_calc) begin
         tod_in = secs_ff[16:0] - day_secs;
      end
      if (cmd.hour_calc) begin
         hour_in = hour_prod[25:21];
      end
      if (cmd.hrem_calc) begin
         hrem_in = tod_ff[11:0] - hour_secs;
      end
      if (cmd.min_calc) begin
         min_in = min_prod[19:14];
      end
      if (cmd.sec_calc) begin
         sec_in = hrem_ff[5:0] - min_secs;
      end
      if (cmd.year_step) begin
         days_in   = days_ff - {7'd0, ylen};
         year_in   = year_ff + 12'd1;
         mod4_in   = mod4_ff + 2'd1;
         mod100_in = (mod100_ff == tscd_pkg::MOD100_LAST) ? 7'd0 : mod100_ff + 7'd1;
         mod400_in = (mod400_ff == tscd_pkg::MOD400_LAST) ? 9'd0 : mod400_ff + 9'd1;
      end
      if (cmd.month_step) begin
         days_in = days_ff - {11'd0, mlen};
         mon_in  = mon_ff + 4'd1;
      end
      if (cmd.out_load) begin
         out_in = {2'd0, sec_ff, min_ff, hour_ff, day_out, month_out, year_ff};
      end
   end

   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      days_ff   <= days_in;
      tod_ff    <= tod_in;
      hour_ff   <= hour_in;
      hrem_ff   <= hrem_in;
      min_ff    <= min_in;
      sec_ff    <= sec_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mon_ff    <= mon_in;
      out_ff    <= out_in;
   end

   assign rsp_data = out_ff;

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> (year_ff < tscd_pkg::LAST_YEAR))
      else $error("year walk passed last representable year");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (mon_ff < tscd_pkg::MONTH_DEC))
      else $error("month walk passed December");

   a_tod_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.hour_calc |-> (tod_ff < tscd_pkg::SECS_PER_DAY))
      else $error("time of day not below one day");

   a_hrem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.min_calc |-> (hrem_ff < tscd_pkg::SECS_PER_HOUR))
      else $error("seconds past the hour not below one hour");

endmodule

`default_nettype wire

[hdl/tscd_ctrl.sv]
// Controller: sequences the divide stages, year and month walk, and result handoff.
`default_nettype none

module tscd_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   input  tscd_pkg::tscd_status_type status,
   output tscd_pkg::tscd_cmd_type   cmd
);

   tscd_pkg::tscd_state_type state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tscd_pkg::ST_IDLE:
            if (req_tvalid) state_in = tscd_pkg::ST_DAYS;
         tscd_pkg::ST_DAYS:
            state_in = tscd_pkg::ST_TOD;
         tscd_pkg::ST_TOD:
            state_in = tscd_pkg::ST_HOURS;
         tscd_pkg::ST_HOURS:
            state_in = tscd_pkg::ST_HOUR_REM;
         tscd_pkg::ST_HOUR_REM:
            state_in = tscd_pkg::ST_MINUTES;
         tscd_pkg::ST_MINUTES:
            state_in = tscd_pkg::ST_SECONDS;
         tscd_pkg::ST_SECONDS:
            state_in = tscd_pkg::ST_YEAR;
         tscd_pkg::ST_YEAR:
            if (status.year_done) state_in = tscd_pkg::ST_MONTH;
         tscd_pkg::ST_MONTH:
            if (status.month_done) state_in = tscd_pkg::ST_FINISH;
         tscd_pkg::ST_FINISH:
            if (out_free) state_in = tscd_pkg::ST_IDLE;
         default:
            state_in = tscd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tscd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         tscd_pkg::ST_DAYS: begin
            cmd.days_calc = 1'b1;
         end
         tscd_pkg::ST_TOD: begin
            cmd.tod_calc = 1'b1;
         end
         tscd_pkg::ST_HOURS: begin
            cmd.hour_calc = 1'b1;
         end
         tscd_pkg::ST_HOUR_REM: begin
            cmd.hrem_calc = 1'b1;
         end
         tscd_pkg::ST_MINUTES: begin
            cmd.min_calc = 1'b1;
         end
         tscd_pkg::ST_SECONDS: begin
            cmd.sec_calc = 1'b1;
         end
         tscd_pkg::ST_YEAR: begin
            cmd.year_step = !status.year_done;
         end
         tscd_pkg::ST_MONTH: begin
            cmd.month_step = !status.month_done;
         end
         tscd_pkg::ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (cmd.out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tscd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == tscd_pkg::ST_DAYS))
      else $error("accepted item did not start the day divide");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == tscd_pkg::ST_IDLE))
      else $error("input ready while an item is in progress");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.days_calc, cmd.tod_calc, cmd.hour_calc, cmd.hrem_calc,
                cmd.min_calc, cmd.sec_calc, cmd.year_step, cmd.month_step, cmd.out_load}))
      else $error("more than one datapath command at once");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for timestamp_to_civil_date_unit: directed table plus random timestamps.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 1080;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned N_DIRECTED   = 19;

   // packed in the same order as rsp_tdata, year in the lowest bits
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } civil_date_type;

   typedef struct {
      logic [31:0]    secs;
      bit             known;
      civil_date_type date;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   civil_date_type   expected_dates [$];
   directed_row_type directed_rows [N_DIRECTED];
   int unsigned      items_sent;
   int unsigned      dates_checked;
   int unsigned      failures;
   int unsigned      leap_days_seen;
   int unsigned      max_year_seen;

   timestamp_to_civil_date_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic bit leap_of(int unsigned yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return yr % 400 == 0;
   endfunction

   function automatic int unsigned month_length(int unsigned mon, bit leap_year);
      int unsigned len;
      case (mon)
         1:        len = leap_year ? 29 : 28;
         3, 5, 8, 10: len = 30;
         default:  len = 31;
      endcase
      return len;
   endfunction

   function automatic civil_date_type make_date(int unsigned yr, int unsigned mon,
                                                int unsigned dy, int unsigned hr,
                                                int unsigned mi, int unsigned se);
      civil_date_type d;
      d.year   = yr[11:0];
      d.month  = mon[3:0];
      d.day    = dy[4:0];
      d.hour   = hr[4:0];
      d.minute = mi[5:0];
      d.second = se[5:0];
      return d;
   endfunction

   // whole years first, then whole months of the year left over
   function automatic civil_date_type civil_date_of(logic [31:0] secs);
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mon;
      int unsigned len;
      days = secs / 32'd86400;
      tod  = secs % 32'd86400;
      yr   = 1970;
      forever begin
         len = leap_of(yr) ? 366 : 365;
         if (days < len) break;
         days -= len;
         yr++;
      end
      mon = 0;
      while (mon < 11) begin
         len = month_length(mon, leap_of(yr));
         if (days < len) break;
         days -= len;
         mon++;
      end
      return make_date(yr, mon + 1, days + 1, tod / 3600, (tod % 3600) / 60, tod % 60);
   endfunction

   function automatic logic [31:0] pick_timestamp();
      int unsigned     sel;
      longint unsigned t;
      sel = $urandom_range(0, 3);
      if (sel < 2) return $urandom;
      t = longint'($urandom_range(0, 49710)) * 86400;
      if (sel == 2) t += $urandom_range(0, 1) ? 86399 : 0;
      else          t += $urandom_range(0, 86399);
      if (t > 64'hFFFF_FFFF) return $urandom;
      return t[31:0];
   endfunction

   task automatic send_timestamp(logic [31:0] secs, civil_date_type want, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      do @(posedge clock); while (!req_tready);
      expected_dates.push_back(want);
      items_sent++;
   endtask

   task automatic check_date(logic [39:0] data);
      civil_date_type got;
      civil_date_type want;
      got = data[37:0];
      if (expected_dates.size() == 0) begin
         if (failures < 10)
            $display("unexpected item %0d-%0d-%0d %0d:%0d:%0d",
                     got.year, got.month, got.day, got.hour, got.minute, got.second);
         failures++;
         return;
      end
      want = expected_dates.pop_front();
      dates_checked++;
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second) begin
         if (failures < 10) begin
            $display("mismatch on item %0d: expected %0d-%0d-%0d %0d:%0d:%0d",
                     dates_checked, want.year, want.month, want.day, want.hour,
                     want.minute, want.second);
            $display("   got %0d-%0d-%0d %0d:%0d:%0d",
                     got.year, got.month, got.day, got.hour, got.minute, got.second);
         end
         failures++;
      end
      if (got.month == 2 && got.day == 29) leap_days_seen++;
      if (got.year > max_year_seen) max_year_seen = got.year;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random stalls, idle-free stretches, and one long hold-off
   initial begin
      int unsigned stall;
      bit          held;
      rsp_tready = 1'b0;
      held       = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held && dates_checked == 50) begin
            held = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = ((dates_checked / 40) % 3 == 1) ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_date(rsp_tdata);
      end
   end

   initial begin
      int unsigned gap;
      logic [31:0] secs;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      items_sent     = 0;
      dates_checked  = 0;
      failures       = 0;
      leap_days_seen = 0;
      max_year_seen  = 0;

      directed_rows = '{
         '{32'd0,          1'b1, make_date(1970, 1, 1, 0, 0, 0)},
         '{32'd59,         1'b1, make_date(1970, 1, 1, 0, 0, 59)},
         '{32'd3599,       1'b1, make_date(1970, 1, 1, 0, 59, 59)},
         '{32'd86399,      1'b1, make_date(1970, 1, 1, 23, 59, 59)},
         '{32'd86400,      1'b1, make_date(1970, 1, 2, 0, 0, 0)},
         '{32'd2678400,    1'b1, make_date(1970, 2, 1, 0, 0, 0)},
         '{32'd31535999,   1'b1, make_date(1970, 12, 31, 23, 59, 59)},
         '{32'd31536000,   1'b1, make_date(1971, 1, 1, 0, 0, 0)},
         '{32'd68169600,   1'b0, '0},   // Feb 29 of the first leap year
         '{32'd94694399,   1'b0, '0},   // last second of a leap year
         '{32'd951782400,  1'b0, '0},   // century year that is leap
         '{32'd4102444800, 1'b0, '0},
         '{32'd4107542400, 1'b0, '0},   // century year that is not leap, Mar 1
         '{32'd2147483647, 1'b0, '0},
         '{32'd2147483648, 1'b0, '0},
         '{32'hAAAA_AAAA,  1'b0, '0},
         '{32'h5555_5555,  1'b0, '0},
         '{32'd4294944000, 1'b1, make_date(2106, 2, 7, 0, 0, 0)},
         '{32'hFFFF_FFFF,  1'b1, make_date(2106, 2, 7, 6, 28, 15)}
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_timestamp(directed_rows[i].secs,
                        directed_rows[i].known ? directed_rows[i].date
                                               : civil_date_of(directed_rows[i].secs),
                        $urandom_range(0, 7));

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         secs = pick_timestamp();
         gap  = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 7);
         send_timestamp(secs, civil_date_of(secs), gap);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d timestamps sent, %0d dates checked, %0d failures",
               items_sent, dates_checked, failures);
      $display("leap days seen: %0d, latest year seen: %0d", leap_days_seen, max_year_seen);
      if (failures == 0 && expected_dates.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
